>>> rtl/core/hsep_pkg.sv
package hsep_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int NUM_SYMBOLS_DEF  = 256;
  localparam int MID_DEPTH        = 4;
  localparam int OUT_DEPTH        = 4;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  symbol;
    logic [31:0] code_word;
    logic [5:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

endpackage

>>> rtl/core/huffman_symbol_encoder_packer_top.sv
// Channel   Ports                          Beat
// input     in_push, in_full, in_item      push && !full: load, encode or flush
// result    out_pop, out_empty, out_item   pop && !empty: one packed byte
//
// An item is taken every cycle while the queue between front and back has room.
// The front reads the code table through a register; the back packer emits one
// byte per cycle while the result queue has room, and pops no new entry while it
// holds a whole pending byte. Loads and encodes of empty codes never reach the back.
// Reset clears the table valid bits and the pending bits at once; no clearing pass.
// A full result queue stalls the back, and a full middle queue raises in_full.
module huffman_symbol_encoder_packer_top #(
  parameter int MAX_CODE_LEN = hsep_pkg::MAX_CODE_LEN_DEF,
  parameter int NUM_SYMBOLS  = hsep_pkg::NUM_SYMBOLS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  hsep_pkg::in_item_t  in_item,
  input  logic                out_pop,
  output logic                out_empty,
  output hsep_pkg::out_item_t out_item
);
  import hsep_pkg::*;

  localparam int EW  = 1 + 6 + MAX_CODE_LEN;
  localparam int MCW = $clog2(MID_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic                    accept;
  logic                    s1_busy;
  logic                    q_push, q_flush, q_pop;
  logic [5:0]              q_len;
  logic [MAX_CODE_LEN-1:0] q_bits;
  logic [EW-1:0]           mid_wdata, mid_rdata;
  logic [MCW-1:0]          mid_cnt;
  logic                    of_push, of_full;
  out_item_t               of_data;
  logic [OCW-1:0]          out_cnt;

  assign accept  = in_push && !in_full;
  assign in_full = ((MCW+1)'(mid_cnt) + (MCW+1)'(s1_busy)) >= (MCW+1)'(MID_DEPTH);

  hsep_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_SYMBOLS  (NUM_SYMBOLS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_item),
    .s1_busy (s1_busy),
    .q_push  (q_push),
    .q_flush (q_flush),
    .q_len   (q_len),
    .q_bits  (q_bits)
  );

  assign mid_wdata = {q_flush, q_len, q_bits};

  hsep_fifo #(
    .W (EW),
    .D (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (mid_wdata),
    .pop   (q_pop),
    .rdata (mid_rdata),
    .count (mid_cnt)
  );

  hsep_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (mid_cnt != '0),
    .q_flush (mid_rdata[EW-1]),
    .q_len   (mid_rdata[EW-2 -: 6]),
    .q_bits  (mid_rdata[MAX_CODE_LEN-1:0]),
    .q_pop   (q_pop),
    .of_full (of_full),
    .of_push (of_push),
    .of_data (of_data)
  );

  assign of_full = (out_cnt == OCW'(OUT_DEPTH));

  hsep_fifo #(
    .W ($bits(out_item_t)),
    .D (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (of_push),
    .wdata (of_data),
    .pop   (out_pop),
    .rdata (out_item),
    .count (out_cnt)
  );

  assign out_empty = (out_cnt == '0);

  a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (mid_cnt != MCW'(MID_DEPTH)))
    else $error("middle queue written while full");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    of_push |-> !of_full)
    else $error("result queue written while full");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (mid_cnt != '0))
    else $error("back popped an empty middle queue");

endmodule

>>> rtl/core/hsep_fifo.sv
module hsep_fifo #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [W-1:0]           wdata,
  input  logic                   pop,
  output logic [W-1:0]           rdata,
  output logic [$clog2(D+1)-1:0] count
);

  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D+1);

  logic [W-1:0]  mem_r [D];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign do_push = push && (cnt_r != CW'(D));
  assign do_pop  = pop && (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign count   = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(D-1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(D-1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/core/hsep_front.sv
module hsep_front #(
  parameter int MAX_CODE_LEN = 32,
  parameter int NUM_SYMBOLS  = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  hsep_pkg::in_item_t      item,
  output logic                    s1_busy,
  output logic                    q_push,
  output logic                    q_flush,
  output logic [5:0]              q_len,
  output logic [MAX_CODE_LEN-1:0] q_bits
);
  import hsep_pkg::*;

  localparam int SW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int XW = MAX_CODE_LEN + 32;

  logic [31:0]            code_mem [NUM_SYMBOLS];
  logic [5:0]             len_mem  [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] vld_r, vld_nxt;

  logic        s1_vld_r, s1_vld_nxt;
  logic        s1_flush_r, s1_flush_nxt;
  logic        s1_hit_r, s1_hit_nxt;
  logic [31:0] code_rd_r;
  logic [5:0]  len_rd_r;

  logic [SW-1:0] idx;
  logic          in_range;
  logic          do_load;
  logic [5:0]    len_sat;
  logic [31:0]   masked;
  logic [6:0]    shamt;
  logic [XW-1:0] shifted;

  assign idx      = item.symbol[SW-1:0];
  assign in_range = ({1'b0, item.symbol} < 9'(NUM_SYMBOLS));
  assign do_load  = accept && (item.opcode == OP_LOAD) && in_range;
  assign len_sat  = (item.code_length > 6'(MAX_CODE_LEN)) ? 6'(MAX_CODE_LEN)
                                                           : item.code_length;

  always_comb begin
    vld_nxt = vld_r;
    if (do_load) begin
      vld_nxt[idx] = 1'b1;
    end
    s1_vld_nxt   = accept && (((item.opcode == OP_ENCODE) && in_range) ||
                              (item.opcode == OP_FLUSH));
    s1_flush_nxt = (item.opcode == OP_FLUSH);
    s1_hit_nxt   = vld_r[idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      vld_r    <= vld_nxt;
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_flush_r <= s1_flush_nxt;
    s1_hit_r   <= s1_hit_nxt;
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      code_mem[idx] <= item.code_word;
      len_mem[idx]  <= len_sat;
    end
    code_rd_r <= code_mem[idx];
    len_rd_r  <= len_mem[idx];
  end

  assign masked  = code_rd_r & ~(32'hFFFF_FFFF << len_rd_r);
  assign shamt   = 7'(MAX_CODE_LEN) - {1'b0, len_rd_r};
  assign shifted = XW'(masked) << shamt;

  assign s1_busy = s1_vld_r;
  assign q_push  = s1_vld_r && (s1_flush_r || (s1_hit_r && (len_rd_r != '0)));
  assign q_flush = s1_flush_r;
  assign q_len   = len_rd_r;
  assign q_bits  = shifted[MAX_CODE_LEN-1:0];

endmodule

>>> rtl/core/hsep_back.sv
module hsep_back #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  logic                    q_flush,
  input  logic [5:0]              q_len,
  input  logic [MAX_CODE_LEN-1:0] q_bits,
  output logic                    q_pop,
  input  logic                    of_full,
  output logic                    of_push,
  output hsep_pkg::out_item_t     of_data
);
  import hsep_pkg::*;

  localparam int WW = MAX_CODE_LEN + 7;
  localparam int CW = $clog2(WW + 1);

  logic [WW-1:0] w_r, w_nxt;
  logic [CW-1:0] wc_r, wc_nxt;
  logic [WW-1:0] merged;
  logic [CW-1:0] merged_cnt;
  logic          busy;

  assign busy       = (wc_r >= CW'(8));
  assign merged     = w_r | ({q_bits, 7'b0} >> wc_r);
  assign merged_cnt = wc_r + CW'(q_len);

  always_comb begin
    w_nxt   = w_r;
    wc_nxt  = wc_r;
    q_pop   = 1'b0;
    of_push = 1'b0;
    of_data = '{out_byte: w_r[WW-1 -: 8], last_of_run: 1'b1};
    if (busy) begin
      if (!of_full) begin
        of_push             = 1'b1;
        of_data.last_of_run = ((wc_r - CW'(8)) < CW'(8));
        w_nxt               = w_r << 8;
        wc_nxt              = wc_r - CW'(8);
      end
    end else if (q_valid) begin
      if (q_flush) begin
        if (wc_r == '0) begin
          q_pop = 1'b1;
        end else if (!of_full) begin
          q_pop   = 1'b1;
          of_push = 1'b1;
          w_nxt   = '0;
          wc_nxt  = '0;
        end
      end else begin
        q_pop = 1'b1;
        if ((merged_cnt >= CW'(8)) && !of_full) begin
          of_push = 1'b1;
          of_data = '{out_byte: merged[WW-1 -: 8],
                      last_of_run: ((merged_cnt - CW'(8)) < CW'(8))};
          w_nxt   = merged << 8;
          wc_nxt  = merged_cnt - CW'(8);
        end else begin
          w_nxt  = merged;
          wc_nxt = merged_cnt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r  <= '0;
      wc_r <= '0;
    end else begin
      w_r  <= w_nxt;
      wc_r <= wc_nxt;
    end
  end

endmodule
